[rtl/ols_pkg.sv]
// ----------------------------------------------------------------------------
// ols_pkg
// Codes, field widths and payload types shared by the ordered list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ols_pkg;

	localparam int FUNC_W  = 2;
	localparam int POS_W   = 8;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 8;

	typedef logic [FUNC_W-1:0]         func_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic signed [DATA_W-1:0]  data_t;
	typedef logic [STAT_W-1:0]         status_t;
	typedef logic [COUNT_W-1:0]        count_t;

	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_DELETE = 2'd1;
	localparam func_t FUNC_READ   = 2'd2;

	localparam status_t STATUS_OK     = 2'd0;
	localparam status_t STATUS_BADPOS = 2'd1;
	localparam status_t STATUS_FULL   = 2'd2;

endpackage

`default_nettype wire

[rtl/ols_req_if.sv]
// ----------------------------------------------------------------------------
// ols_req_if
// Request channel: operation, position and word to insert.
// ----------------------------------------------------------------------------
`default_nettype none

interface ols_req_if;

	logic            valid;
	logic            ready;
	ols_pkg::func_t  func;
	ols_pkg::pos_t   position;
	ols_pkg::data_t  data_in;

	modport source (output valid, output func, output position, output data_in,
		input ready);
	modport sink (input valid, input func, input position, input data_in,
		output ready);

endinterface

`default_nettype wire

[rtl/ols_rsp_if.sv]
// ----------------------------------------------------------------------------
// ols_rsp_if
// Response channel: status, returned word, entry count and empty flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ols_rsp_if;

	logic              valid;
	logic              ready;
	ols_pkg::status_t  status;
	ols_pkg::data_t    data_out;
	ols_pkg::count_t   count;
	logic              is_empty;

	modport source (output valid, output status, output data_out, output count,
		output is_empty, input ready);
	modport sink (input valid, input status, input data_out, input count,
		input is_empty, output ready);

endinterface

`default_nettype wire

[rtl/ordered_list_store.sv]
// ----------------------------------------------------------------------------
// ordered_list_store
// List of signed words in positions 1..count with insert, delete and read.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                                   transfer when
//  req      in   func, position, data_in                  valid && ready
//  rsp      out  status, data_out, count, is_empty        valid && ready
//
//  Request handling: an insert at p with n entries moves the n-p+1 words at
//  p..n up through the entry RAM, one per cycle, then drains the read data,
//  writes the new word and responds. A delete reads the n-p+1 words from p,
//  returns the first and moves the rest down; a read fetches one word. Errors
//  and the unused code go straight to the response. Idle follows each response.
//  The single read and single write port of the entry RAM set the pace.
//  Reset clears the count and the sequencer; entry contents are left as is.
//  req.ready is high only when idle; a stalled response holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store #(
	parameter int CAPACITY = 128
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ols_req_if.sink    req,
	ols_rsp_if.source  rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = ((CW > ols_pkg::POS_W) ? CW : ols_pkg::POS_W) + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_RESP  = 2'd2;

	logic [1:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_left_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      raddr_prev_q;
	logic [AW-1:0]      tail_q;
	logic               rvalid_q;
	logic               first_q;
	logic               rfirst_q;
	ols_pkg::func_t     func_q;
	ols_pkg::data_t     data_q;
	ols_pkg::data_t     dout_q;
	ols_pkg::status_t   status_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	ols_pkg::data_t     ram_wdata;
	ols_pkg::data_t     ram_rdata;

	logic [MW-1:0]      pos_ext;
	logic [MW-1:0]      cnt_ext;
	logic               req_xfer;
	logic               rd_en;
	logic               shift_done;

	assign pos_ext    = MW'(req.position);
	assign cnt_ext    = MW'(cnt_q);
	assign req_xfer   = req.valid && req.ready;
	assign rd_en      = (state_q == ST_SHIFT) && (rd_left_q != '0);
	assign shift_done = (state_q == ST_SHIFT) && (rd_left_q == '0) && !rvalid_q;

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = (state_q == ST_RESP);
	assign rsp.status   = status_q;
	assign rsp.data_out = dout_q;
	assign rsp.count    = cnt_ext[ols_pkg::COUNT_W-1:0];
	assign rsp.is_empty = (cnt_q == '0);

	// ram write side: moved word, or the new word at the end of an insert
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = data_q;
		if (state_q == ST_SHIFT) begin
			if (rvalid_q) begin
				ram_wdata = ram_rdata;
				if (func_q == ols_pkg::FUNC_INSERT) begin
					ram_we    = 1'b1;
					ram_waddr = raddr_prev_q + AW'(1);
				end else if (!rfirst_q && func_q == ols_pkg::FUNC_DELETE) begin
					ram_we    = 1'b1;
					ram_waddr = raddr_prev_q - AW'(1);
				end
			end else if (shift_done && func_q == ols_pkg::FUNC_INSERT) begin
				ram_we = 1'b1;
			end
		end
	end

	ols_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_left_q <= '0;
			rvalid_q  <= 1'b0;
			first_q   <= 1'b0;
			rfirst_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						func_q   <= req.func;
						data_q   <= req.data_in;
						dout_q   <= '0;
						status_q <= ols_pkg::STATUS_OK;
						rvalid_q <= 1'b0;
						first_q  <= 1'b0;
						tail_q   <= AW'(pos_ext - MW'(1));
						state_q  <= ST_RESP;
						if (req.func == ols_pkg::FUNC_INSERT) begin
							if (pos_ext == '0 || pos_ext > cnt_ext + MW'(1)) begin
								status_q <= ols_pkg::STATUS_BADPOS;
							end else if (cnt_q == CW'(CAPACITY)) begin
								status_q <= ols_pkg::STATUS_FULL;
							end else begin
								rd_left_q <= CW'(cnt_ext + MW'(1) - pos_ext);
								ptr_q     <= AW'(cnt_q - CW'(1));
								state_q   <= ST_SHIFT;
							end
						end else if (req.func == ols_pkg::FUNC_DELETE ||
							req.func == ols_pkg::FUNC_READ) begin
							if (pos_ext == '0 || pos_ext > cnt_ext) begin
								status_q <= ols_pkg::STATUS_BADPOS;
							end else begin
								rd_left_q <= (req.func == ols_pkg::FUNC_DELETE) ?
									CW'(cnt_ext + MW'(1) - pos_ext) : CW'(1);
								ptr_q     <= AW'(pos_ext - MW'(1));
								first_q   <= 1'b1;
								state_q   <= ST_SHIFT;
							end
						end
					end
				end
				ST_SHIFT: begin
					rvalid_q <= rd_en;
					if (rd_en) begin
						rd_left_q    <= rd_left_q - CW'(1);
						raddr_prev_q <= ptr_q;
						rfirst_q     <= first_q;
						first_q      <= 1'b0;
						ptr_q        <= (func_q == ols_pkg::FUNC_INSERT) ?
							ptr_q - AW'(1) : ptr_q + AW'(1);
					end
					// first word read back by delete or read is the result
					if (rvalid_q && rfirst_q && func_q != ols_pkg::FUNC_INSERT) begin
						dout_q <= ram_rdata;
					end
					if (shift_done) begin
						if (func_q == ols_pkg::FUNC_INSERT) begin
							cnt_q <= cnt_q + CW'(1);
						end else if (func_q == ols_pkg::FUNC_DELETE) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/ols_ram.sv]
// ----------------------------------------------------------------------------
// ols_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ols_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire ols_pkg::data_t   wdata,
	input  wire logic [AW-1:0]    raddr,
	output ols_pkg::data_t        rdata
);

	ols_pkg::data_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/ols_checker.sv]
// ----------------------------------------------------------------------------
// ols_checker
// Port-level checks on the ordered list store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ols_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire ols_pkg::status_t  rsp_status,
	input wire ols_pkg::data_t    rsp_data_out
);

	// never takes a request while a result is waiting
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request side ready while a result is pending");

	// busy right after a request transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready again straight after a request transfer");

	// free again once the result is taken
	a_idle_after_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid))
		else $error("not idle after a response transfer");

	// failed requests return no word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != ols_pkg::STATUS_OK) |-> (rsp_data_out == '0))
		else $error("non-zero data with an error status");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data_out)
		&& $stable(rsp_status)))
		else $error("stalled response changed");

endmodule

bind ordered_list_store ols_checker u_ols_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_data_out (rsp.data_out)
);

`default_nettype wire
